@@ src/svic_pkg.sv @@
// Shared types, constants and font table for the CHIP-8 instruction core.
`default_nettype none
package svic_pkg;
    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int START_PC    = 512;
    localparam int ADDR_W      = 12;
    localparam int SCR_BYTES   = SCREEN_W / 8 * SCREEN_H;
    localparam int SCR_AW      = $clog2(SCR_BYTES);
    localparam logic [11:0] FONT_BASE = 12'h050;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_EXEC  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [7:0]  wdata;
        logic [15:0] key_mask;
        logic [7:0]  rand_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  pixel_byte;
        logic [11:0] next_pc;
        logic [15:0] executed_opcode;
        logic [7:0]  flag_reg;
        logic        waiting_for_key;
        logic        screen_changed;
        logic        sound_on;
    } rsp_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] g [0:79];
        g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        if (i < 7'd80) return g[i];
        return 8'h00;
    endfunction
endpackage
`default_nettype wire

@@ src/svic_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module svic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ src/svic_front.sv @@
// Front end: two-word command queue.
`default_nettype none
module svic_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire svic_pkg::cmd_t in_cmd,
    output logic                q_valid,
    input  wire logic           q_ready,
    output svic_pkg::cmd_t      q_cmd
);
    import svic_pkg::*;

    cmd_t       buf_reg [0:1];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                buf_reg[wr_reg] <= in_cmd;
                wr_reg <= ~wr_reg;
            end
            if (q_valid && q_ready) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
        end
    end
endmodule
`default_nettype wire

@@ src/svic_back.sv @@
// Back end: instruction sequencer over memory, screen and stack RAMs.
`default_nettype none
module svic_back #(
    parameter int STACK_DEPTH = svic_pkg::STACK_DEPTH,
    parameter int START_PC    = svic_pkg::START_PC
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire svic_pkg::cmd_t q_cmd,
    output logic                r_valid,
    input  wire logic           r_ready,
    output svic_pkg::rsp_t      r_data
);
    import svic_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_FILL, S_SREAD, S_SREAD2, S_F0, S_F1, S_F2, S_EXEC,
        S_CLR, S_RET, S_RET2, S_D_RD, S_D_WAIT, S_D_SRD, S_D_SWAIT, S_D_L,
        S_D_R, S_D_NEXT, S_BCD, S_ST, S_LD, S_LD2, S_DIV, S_OUT
    } state_t;

    state_t       state_reg;
    logic [11:0]  fill_reg;
    cmd_t         cmd_reg;
    logic [7:0]   v_reg [0:15];
    logic [11:0]  i_reg, pc_reg, npc_reg;
    logic [SP_W-1:0] sp_reg;
    logic [7:0]   dt_reg, st_reg;
    logic [15:0]  word_reg;
    logic [7:0]   pix_reg;
    logic         wait_reg, chg_reg, hit_reg;
    logic [3:0]   cnt_reg;
    logic [7:0]   line_reg, sl_reg, sr_reg, dv_reg;
    logic [3:0]   dig_reg [0:2];
    logic [1:0]   dix_reg;
    logic [5:0]   x0_reg;
    logic [4:0]   y_reg;
    logic         rv_reg;
    rsp_t         rsp_reg;

    // memory port
    logic        m_we;
    logic [11:0] m_addr;
    logic [7:0]  m_wd, m_rd;
    // screen port
    logic              s_we;
    logic [SCR_AW-1:0] s_addr;
    logic [7:0]        s_wd, s_rd;
    // stack port
    logic            k_we;
    logic [SP_W-1:0] k_addr;
    logic [11:0]     k_rd;

    svic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .aclk(aclk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
    svic_ram #(.WIDTH(8), .DEPTH(SCR_BYTES)) u_scr (
        .aclk(aclk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
    svic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
        .aclk(aclk), .we(k_we), .addr(k_addr), .wdata(npc_reg), .rdata(k_rd));

    logic [3:0]  wx, wy;
    logic [7:0]  vx, vy, kk;
    logic [15:0] sprite;
    logic [8:0]  sum9;
    logic [11:0] font_off;
    logic [7:0]  bcd_unit;
    logic [3:0]  key_num;
    assign wx   = word_reg[11:8];
    assign wy   = word_reg[7:4];
    assign kk   = word_reg[7:0];
    assign vx   = v_reg[wx];
    assign vy   = v_reg[wy];
    assign sum9 = {1'b0, vx} + {1'b0, vy};
    // sprite row shifted to pixel column within a byte pair
    assign sprite = {line_reg, 8'h00} >> x0_reg[2:0];
    assign font_off = fill_reg - FONT_BASE;
    assign bcd_unit = (dix_reg == 2'd0) ? 8'd100 : 8'd10;

    // lowest pressed key
    always_comb begin
        key_num = 4'h0;
        for (int k = 15; k >= 0; k--)
            if (cmd_reg.key_mask[k]) key_num = 4'(k);
    end

    always_comb begin
        m_we = 1'b0; m_addr = cmd_reg.addr; m_wd = cmd_reg.wdata;
        s_we = 1'b0; s_addr = cmd_reg.addr[SCR_AW-1:0]; s_wd = 8'h00;
        k_we = 1'b0; k_addr = sp_reg;
        unique case (state_reg)
            S_INIT: begin
                // zero the whole memory, font glyphs at 0x50
                m_we = 1'b1; m_addr = fill_reg;
                m_wd = (font_off < 12'd80) ? font_byte(font_off[6:0]) : 8'h00;
            end
            S_FILL:  m_we = 1'b1;
            S_F0:    m_addr = pc_reg;
            S_F1:    m_addr = pc_reg + 12'd1;
            S_CLR: begin
                s_we = 1'b1; s_addr = SCR_AW'(fill_reg);
            end
            S_EXEC:  k_we = (word_reg[15:12] == 4'h2);
            S_D_RD:  m_addr = i_reg + 12'(cnt_reg);
            S_D_SRD: s_addr = {y_reg, x0_reg[5:3]};
            S_D_SWAIT: s_addr = {y_reg, x0_reg[5:3] + 3'd1};
            S_D_L: begin
                s_we = 1'b1; s_addr = {y_reg, x0_reg[5:3]};
                s_wd = sl_reg ^ sprite[15:8];
            end
            S_D_R: begin
                s_we = (x0_reg[5:3] != 3'd7) && (sprite[7:0] != 8'h00);
                s_addr = {y_reg, x0_reg[5:3] + 3'd1};
                s_wd = sr_reg ^ sprite[7:0];
            end
            S_BCD: begin
                m_we = 1'b1; m_addr = i_reg + 12'(dix_reg);
                m_wd = {4'h0, dig_reg[dix_reg]};
            end
            S_ST: begin
                m_we = 1'b1; m_addr = i_reg + 12'(cnt_reg); m_wd = v_reg[cnt_reg];
            end
            S_LD:    m_addr = i_reg + 12'(cnt_reg);
            default: ;
        endcase
    end

    assign q_ready = (state_reg == S_IDLE);
    assign r_valid = rv_reg;
    assign r_data  = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            fill_reg  <= '0;
            for (int k = 0; k < 16; k++) v_reg[k] <= '0;
            i_reg     <= '0;
            pc_reg    <= 12'(START_PC);
            sp_reg    <= '0;
            dt_reg    <= '0;
            st_reg    <= '0;
            rv_reg    <= 1'b0;
        end else begin
            if (rv_reg && r_ready && state_reg != S_OUT) rv_reg <= 1'b0;
            unique case (state_reg)
                S_INIT: begin
                    fill_reg <= fill_reg + 12'd1;
                    if (fill_reg == 12'(MEM_BYTES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (q_valid) begin
                    cmd_reg  <= q_cmd;
                    pix_reg  <= '0; word_reg <= '0;
                    wait_reg <= 1'b0; chg_reg <= 1'b0;
                    npc_reg  <= pc_reg;
                    unique case (op_t'(q_cmd.op))
                        OP_WRITE: state_reg <= S_FILL;
                        OP_EXEC:  state_reg <= S_F0;
                        OP_READ:  state_reg <= S_SREAD;
                        OP_NOP:   state_reg <= S_OUT;
                    endcase
                end
                S_FILL:   state_reg <= S_OUT;
                S_SREAD:  state_reg <= S_SREAD2;
                S_SREAD2: begin
                    pix_reg <= (cmd_reg.addr < 12'(SCR_BYTES)) ? s_rd : 8'h00;
                    state_reg <= S_OUT;
                end
                S_F0: state_reg <= S_F1;
                S_F1: begin
                    word_reg[15:8] <= m_rd;
                    state_reg <= S_F2;
                end
                S_F2: begin
                    word_reg[7:0] <= m_rd;
                    npc_reg <= pc_reg + 12'd2;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_OUT;
                    unique case (word_reg[15:12])
                        4'h0: if (word_reg == 16'h00E0) begin
                            chg_reg <= 1'b1; fill_reg <= '0; state_reg <= S_CLR;
                        end else if (word_reg == 16'h00EE) begin
                            sp_reg <= (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1)
                                                     : sp_reg - SP_W'(1);
                            state_reg <= S_RET;
                        end
                        4'h1: npc_reg <= word_reg[11:0];
                        4'h2: begin
                            sp_reg <= (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0
                                                                       : sp_reg + SP_W'(1);
                            npc_reg <= word_reg[11:0];
                        end
                        4'h3: if (vx == kk) npc_reg <= npc_reg + 12'd2;
                        4'h4: if (vx != kk) npc_reg <= npc_reg + 12'd2;
                        4'h5: if (vx == vy) npc_reg <= npc_reg + 12'd2;
                        4'h6: v_reg[wx] <= kk;
                        4'h7: v_reg[wx] <= vx + kk;
                        4'h8: unique case (word_reg[3:0])
                            4'h0: v_reg[wx] <= vy;
                            4'h1: v_reg[wx] <= vx | vy;
                            4'h2: v_reg[wx] <= vx & vy;
                            4'h3: v_reg[wx] <= vx ^ vy;
                            4'h4: begin
                                v_reg[15] <= {7'd0, sum9[8]}; v_reg[wx] <= sum9[7:0];
                            end
                            4'h5: begin
                                v_reg[15] <= {7'd0, vx > vy}; v_reg[wx] <= vx - vy;
                            end
                            4'h6: begin
                                v_reg[15] <= {7'd0, vx[0]}; v_reg[wx] <= vx >> 1;
                            end
                            4'h7: begin
                                v_reg[15] <= {7'd0, vy > vx}; v_reg[wx] <= vy - vx;
                            end
                            4'hE: begin
                                v_reg[15] <= {7'd0, vx[7]}; v_reg[wx] <= vx << 1;
                            end
                            default: ;
                        endcase
                        4'h9: if (vx != vy) npc_reg <= npc_reg + 12'd2;
                        4'hA: i_reg <= word_reg[11:0];
                        4'hB: npc_reg <= word_reg[11:0] + {4'h0, v_reg[0]};
                        4'hC: v_reg[wx] <= cmd_reg.rand_byte & kk;
                        4'hD: begin
                            chg_reg <= 1'b1; hit_reg <= 1'b0; cnt_reg <= '0;
                            x0_reg <= vx[5:0]; y_reg <= vy[4:0];
                            state_reg <= S_D_NEXT;
                        end
                        4'hE: begin
                            if ((kk == 8'h9E && cmd_reg.key_mask[vx[3:0]]) ||
                                (kk == 8'hA1 && !cmd_reg.key_mask[vx[3:0]]))
                                npc_reg <= npc_reg + 12'd2;
                        end
                        4'hF: unique case (kk)
                            8'h07: v_reg[wx] <= dt_reg;
                            8'h0A: if (cmd_reg.key_mask == 16'h0) begin
                                npc_reg <= pc_reg; wait_reg <= 1'b1;
                            end else begin
                                v_reg[wx] <= {4'h0, key_num};
                            end
                            8'h15: dt_reg <= vx;
                            8'h18: st_reg <= vx;
                            8'h1E: i_reg <= i_reg + {4'h0, vx};
                            8'h29: i_reg <= FONT_BASE + {6'h0, vx[3:0], 2'b00}
                                            + {8'h0, vx[3:0]};
                            8'h33: begin
                                dv_reg <= vx; dix_reg <= 2'd0;
                                dig_reg[0] <= '0; dig_reg[1] <= '0; dig_reg[2] <= '0;
                                state_reg <= S_DIV;
                            end
                            8'h55: begin cnt_reg <= '0; state_reg <= S_ST; end
                            8'h65: begin cnt_reg <= '0; state_reg <= S_LD; end
                            default: ;
                        endcase
                    endcase
                end
                S_CLR: begin
                    fill_reg <= fill_reg + 12'd1;
                    if (fill_reg == 12'(SCR_BYTES - 1)) state_reg <= S_OUT;
                end
                S_RET:  state_reg <= S_RET2;
                S_RET2: begin npc_reg <= k_rd; state_reg <= S_OUT; end
                // hundreds, then tens by repeated subtraction; remainder is ones
                S_DIV: begin
                    if (dix_reg == 2'd2) begin
                        dig_reg[2] <= dv_reg[3:0];
                        dix_reg <= 2'd0;
                        state_reg <= S_BCD;
                    end else if (dv_reg >= bcd_unit) begin
                        dv_reg <= dv_reg - bcd_unit;
                        dig_reg[dix_reg] <= dig_reg[dix_reg] + 4'd1;
                    end else begin
                        dix_reg <= dix_reg + 2'd1;
                    end
                end
                S_BCD: begin
                    dix_reg <= dix_reg + 2'd1;
                    if (dix_reg == 2'd2) state_reg <= S_OUT;
                end
                S_ST: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == wx) state_reg <= S_OUT;
                end
                S_LD: state_reg <= S_LD2;
                S_LD2: begin
                    v_reg[cnt_reg] <= m_rd;
                    cnt_reg <= cnt_reg + 4'd1;
                    state_reg <= (cnt_reg == wx) ? S_OUT : S_LD;
                end
                S_D_NEXT: begin
                    if (cnt_reg == word_reg[3:0] ||
                        (cnt_reg != 4'd0 && y_reg == 5'd0)) begin
                        v_reg[15] <= {7'd0, hit_reg};
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_D_RD;
                    end
                end
                S_D_RD:   state_reg <= S_D_WAIT;
                S_D_WAIT: begin line_reg <= m_rd; state_reg <= S_D_SRD; end
                S_D_SRD:  state_reg <= S_D_SWAIT;
                S_D_SWAIT: begin sl_reg <= s_rd; state_reg <= S_D_L; end
                S_D_L: begin
                    // right byte read was issued in S_D_SWAIT
                    if ((sl_reg & sprite[15:8]) != 8'h00) hit_reg <= 1'b1;
                    sr_reg <= s_rd;
                    state_reg <= S_D_R;
                end
                S_D_R: begin
                    if (x0_reg[5:3] != 3'd7 && (sr_reg & sprite[7:0]) != 8'h00)
                        hit_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 4'd1;
                    y_reg <= y_reg + 5'd1;
                    state_reg <= S_D_NEXT;
                end
                S_OUT: if (!rv_reg || r_ready) begin
                    pc_reg <= npc_reg;
                    rv_reg <= 1'b1;
                    rsp_reg.pixel_byte      <= pix_reg;
                    rsp_reg.next_pc         <= npc_reg;
                    rsp_reg.executed_opcode <= word_reg;
                    rsp_reg.flag_reg        <= v_reg[15];
                    rsp_reg.waiting_for_key <= wait_reg;
                    rsp_reg.screen_changed  <= chg_reg;
                    rsp_reg.sound_on        <= (st_reg != 8'h00);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/sprite_vm_instruction_core.sv @@
// CHIP-8 instruction core: request channel s_*, one result word per request on m_*.
// Each s_ word writes a program byte (op 0), runs one instruction (op 1) or
// reads a screen byte (op 2); op 3 does nothing but still returns a word.
// A front queue of two words takes requests while the back end executes;
// the back end returns one m_ word per request, in order.
// An 00E0 clears the screen one screen byte per cycle.
// One item is executed at a time, limited by the single memory and screen
// RAM ports.
// After reset the back end first zeroes memory and writes the
// hex font at 0x50, taking no work from the queue; the front queue still fills.
// The screen and return stack hold no reset value; read only what was written.
// If m_ready is low the finished word is held in an output register and the
// next request may complete into it only once taken.
`default_nettype none
module sprite_vm_instruction_core #(
    parameter int STACK_DEPTH = svic_pkg::STACK_DEPTH,
    parameter int START_PC    = svic_pkg::START_PC
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [11:0] s_addr,
    input  wire logic [7:0]  s_wdata,
    input  wire logic [15:0] s_key_mask,
    input  wire logic [7:0]  s_rand_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_pixel_byte,
    output logic [11:0]      m_next_pc,
    output logic [15:0]      m_executed_opcode,
    output logic [7:0]       m_flag_reg,
    output logic             m_waiting_for_key,
    output logic             m_screen_changed,
    output logic             m_sound_on
);
    import svic_pkg::*;

    cmd_t in_cmd, q_cmd;
    rsp_t rsp;
    logic q_valid, q_ready;

    assign in_cmd = '{op: s_op, addr: s_addr, wdata: s_wdata,
                      key_mask: s_key_mask, rand_byte: s_rand_byte};

    svic_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

    svic_back #(.STACK_DEPTH(STACK_DEPTH), .START_PC(START_PC)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .r_valid(m_valid), .r_ready(m_ready), .r_data(rsp));

    assign m_pixel_byte      = rsp.pixel_byte;
    assign m_next_pc         = rsp.next_pc;
    assign m_executed_opcode = rsp.executed_opcode;
    assign m_flag_reg        = rsp.flag_reg;
    assign m_waiting_for_key = rsp.waiting_for_key;
    assign m_screen_changed  = rsp.screen_changed;
    assign m_sound_on        = rsp.sound_on;
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the CHIP-8 instruction core: scoreboard, stimulus and checks.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import svic_pkg::*;

    // Predicts the CHIP-8 machine state and holds the result words still owed by the block.
    class chip8_scoreboard;
        logic [7:0]  mem [0:4095];
        logic [7:0]  vreg [0:15];
        logic [11:0] idx;
        logic [11:0] pc;
        logic [11:0] stk [0:15];
        bit          stk_set [0:15];
        logic [3:0]  sp;
        logic [7:0]  scr [0:255];
        logic [7:0]  dly;
        logic [7:0]  snd;
        rsp_t        owed [$];
        int          errors;
        int          checked;
        int          draws;
        int          clears;
        int          execs;

        function new();
            logic [7:0] glyph [0:79];
            glyph = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
                      8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
                      8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
                      8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
                      8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
                      8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
                      8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
                      8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
            foreach (mem[i]) mem[i] = 8'h00;
            foreach (glyph[i]) mem[FONT_BASE + i] = glyph[i];
            foreach (vreg[i]) vreg[i] = 8'h00;
            foreach (stk[i]) begin
                stk[i] = '0;
                stk_set[i] = 0;
            end
            foreach (scr[i]) scr[i] = 8'h00;
            idx = '0;
            pc = 12'(START_PC);
            sp = '0;
            dly = '0;
            snd = '0;
            errors = 0;
            checked = 0;
            draws = 0;
            clears = 0;
            execs = 0;
        endfunction

        function logic [7:0] sprite_draw(logic [3:0] xr, logic [3:0] yr, logic [3:0] h);
            int x0;
            int y0;
            int y;
            int x;
            int bi;
            logic [7:0] line;
            logic [7:0] bitm;
            logic [7:0] hit;
            x0 = vreg[xr] % 64;
            y0 = vreg[yr] % 32;
            hit = 0;
            for (int r = 0; r < h; r++) begin
                y = y0 + r;
                line = mem[12'(idx + r)];
                if (y >= 32) break;
                for (int c = 0; c < 8; c++) begin
                    x = x0 + c;
                    if (x >= 64) break;
                    if (line[7 - c]) begin
                        bi = y * 8 + (x >> 3);
                        bitm = 8'h80 >> (x & 7);
                        if (scr[bi] & bitm) hit = 1;
                        scr[bi] ^= bitm;
                    end
                end
            end
            return hit;
        endfunction

        function void note(cmd_t c);
            rsp_t        e;
            logic [15:0] w;
            logic [11:0] npc;
            logic [3:0]  x;
            logic [3:0]  y;
            logic [3:0]  n;
            logic [7:0]  kk;
            logic [7:0]  a;
            logic [7:0]  b;
            int          k;
            e = '0;
            if (c.op == OP_WRITE) begin
                mem[c.addr] = c.wdata;
            end else if (c.op == OP_READ) begin
                if (c.addr < 256) e.pixel_byte = scr[c.addr];
            end else if (c.op == OP_EXEC) begin
                execs++;
                w = {mem[pc], mem[12'(pc + 1)]};
                e.executed_opcode = w;
                x = w[11:8];
                y = w[7:4];
                n = w[3:0];
                kk = w[7:0];
                npc = pc + 2;
                a = vreg[x];
                b = vreg[y];
                case (w[15:12])
                    4'h0: begin
                        if (w == 16'h00E0) begin
                            foreach (scr[i]) scr[i] = 0;
                            e.screen_changed = 1;
                            clears++;
                        end else if (w == 16'h00EE) begin
                            sp = sp - 1;
                            npc = stk[sp];
                        end
                    end
                    4'h1: npc = w[11:0];
                    4'h2: begin
                        stk[sp] = npc;
                        stk_set[sp] = 1;
                        sp = sp + 1;
                        npc = w[11:0];
                    end
                    4'h3: if (a == kk) npc += 2;
                    4'h4: if (a != kk) npc += 2;
                    4'h5: if (a == b) npc += 2;
                    4'h6: vreg[x] = kk;
                    4'h7: vreg[x] = a + kk;
                    4'h8: begin
                        case (n)
                            4'h0: vreg[x] = b;
                            4'h1: vreg[x] = a | b;
                            4'h2: vreg[x] = a & b;
                            4'h3: vreg[x] = a ^ b;
                            4'h4: begin
                                vreg[15] = ({1'b0, a} + b > 9'hFF);
                                vreg[x] = a + b;
                            end
                            4'h5: begin
                                vreg[15] = (a > b);
                                vreg[x] = a - b;
                            end
                            4'h6: begin
                                vreg[15] = a[0];
                                vreg[x] = a >> 1;
                            end
                            4'h7: begin
                                vreg[15] = (b > a);
                                vreg[x] = b - a;
                            end
                            4'hE: begin
                                vreg[15] = a[7];
                                vreg[x] = a << 1;
                            end
                            default: ;
                        endcase
                    end
                    4'h9: if (a != b) npc += 2;
                    4'hA: idx = w[11:0];
                    4'hB: npc = w[11:0] + vreg[0];
                    4'hC: vreg[x] = c.rand_byte & kk;
                    4'hD: begin
                        vreg[15] = sprite_draw(x, y, n);
                        e.screen_changed = 1;
                        draws++;
                    end
                    4'hE: begin
                        if ((kk == 8'h9E && c.key_mask[a[3:0]]) ||
                            (kk == 8'hA1 && !c.key_mask[a[3:0]])) npc += 2;
                    end
                    default: begin
                        case (kk)
                            8'h07: vreg[x] = dly;
                            8'h0A: begin
                                if (c.key_mask == 0) begin
                                    npc = pc;
                                    e.waiting_for_key = 1;
                                end else begin
                                    for (k = 0; k < 16; k++) if (c.key_mask[k]) break;
                                    vreg[x] = 8'(k);
                                end
                            end
                            8'h15: dly = a;
                            8'h18: snd = a;
                            8'h1E: idx = idx + a;
                            8'h29: idx = FONT_BASE + a[3:0] * 5;
                            8'h33: begin
                                mem[idx] = a / 100;
                                mem[12'(idx + 1)] = (a / 10) % 10;
                                mem[12'(idx + 2)] = a % 10;
                            end
                            8'h55: for (k = 0; k <= x; k++) mem[12'(idx + k)] = vreg[k];
                            8'h65: for (k = 0; k <= x; k++) vreg[k] = mem[12'(idx + k)];
                            default: ;
                        endcase
                    end
                endcase
                pc = npc;
            end
            e.next_pc = pc;
            e.flag_reg = vreg[15];
            e.sound_on = (snd != 0);
            owed.push_back(e);
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(rsp_t r);
            rsp_t e;
            if (owed.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            cmp("pixel_byte", e.pixel_byte, r.pixel_byte);
            cmp("next_pc", e.next_pc, r.next_pc);
            cmp("executed_opcode", e.executed_opcode, r.executed_opcode);
            cmp("flag_reg", e.flag_reg, r.flag_reg);
            cmp("waiting_for_key", e.waiting_for_key, r.waiting_for_key);
            cmp("screen_changed", e.screen_changed, r.screen_changed);
            cmp("sound_on", e.sound_on, r.sound_on);
        endfunction
    endclass

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_op = '0;
    logic [11:0] s_addr = '0;
    logic [7:0]  s_wdata = '0;
    logic [15:0] s_key_mask = '0;
    logic [7:0]  s_rand_byte = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [7:0]  m_pixel_byte;
    logic [11:0] m_next_pc;
    logic [15:0] m_executed_opcode;
    logic [7:0]  m_flag_reg;
    logic        m_waiting_for_key;
    logic        m_screen_changed;
    logic        m_sound_on;

    chip8_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    int  words_sent = 0;
    int  quiet = 0;

    sprite_vm_instruction_core dut (.*);

    always #1 aclk = ~aclk;

    // watchdog: no handshake on either side for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: sample at rising edge, change ready at falling edge
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check('{m_pixel_byte, m_next_pc, m_executed_opcode, m_flag_reg,
                           m_waiting_for_key, m_screen_changed, m_sound_on});
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 0;
            end
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic put(logic [1:0] op, logic [11:0] addr, logic [7:0] wd,
                       logic [15:0] keys, logic [7:0] rnd);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_op = op;
        s_addr = addr;
        s_wdata = wd;
        s_key_mask = keys;
        s_rand_byte = rnd;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        sb.note('{op, addr, wd, keys, rnd});
        words_sent++;
    endtask

    // place an instruction at the predicted pc, then run it
    task automatic run_instr(logic [15:0] w, logic [15:0] keys, logic [7:0] rnd);
        logic [11:0] at;
        at = sb.pc;
        put(OP_WRITE, at, w[15:8], 16'($urandom), 8'($urandom));
        put(OP_WRITE, at + 12'd1, w[7:0], 16'($urandom), 8'($urandom));
        put(OP_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
    endtask

    function automatic logic [15:0] pick_instr();
        logic [15:0] w;
        int          sel;
        w = 16'($urandom);
        case (w[15:12])
            4'h0: begin
                sel = $urandom_range(9);
                if (sel == 0) w = 16'h00E0;
                else if (sel < 6 && sb.stk_set[sb.sp - 4'd1]) w = 16'h00EE;
                else if (sel < 6) w = {4'h2, w[11:0]};
            end
            4'hD: w[3:0] = ($urandom_range(7) == 0) ? 4'hF : 4'($urandom_range(6));
            4'hE: begin
                sel = $urandom_range(4);
                if (sel < 2) w[7:0] = 8'h9E;
                else if (sel < 4) w[7:0] = 8'hA1;
            end
            4'hF: begin
                case ($urandom_range(10))
                    0: w[7:0] = 8'h07;
                    1: w[7:0] = 8'h0A;
                    2: w[7:0] = 8'h15;
                    3: w[7:0] = 8'h18;
                    4: w[7:0] = 8'h1E;
                    5: w[7:0] = 8'h29;
                    6: w[7:0] = 8'h33;
                    7: w[7:0] = 8'h55;
                    8: w[7:0] = 8'h65;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        int sel;
        int phase;
        logic [15:0] keys;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: clear first so every screen byte is defined
        run_instr(16'h00E0, 16'h0000, 8'h00);
        run_instr(16'h60FF, 16'h0000, 8'h00);
        run_instr(16'h6101, 16'h0000, 8'h00);
        run_instr(16'h8014, 16'h0000, 8'h00);    // carry out
        run_instr(16'h6080, 16'h0000, 8'h00);
        run_instr(16'h800E, 16'h0000, 8'h00);    // shift out bit 7
        run_instr(16'hA050, 16'h0000, 8'h00);
        run_instr(16'h603C, 16'h0000, 8'h00);
        run_instr(16'h611E, 16'h0000, 8'h00);
        run_instr(16'hD015, 16'h0000, 8'h00);    // clipped at right and bottom
        run_instr(16'hD015, 16'h0000, 8'h00);    // same sprite: collision
        run_instr(16'hD010, 16'h0000, 8'h00);    // zero height
        run_instr(16'hF00A, 16'h0000, 8'h00);    // no key: waits
        run_instr(16'hF00A, 16'h8000, 8'h00);
        run_instr(16'hCFFF, 16'hFFFF, 8'hFF);
        put(OP_READ, 12'd0, 8'h00, 16'h0000, 8'h00);
        put(OP_READ, 12'd255, 8'h00, 16'h0000, 8'h00);
        put(OP_READ, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        put(OP_NOP, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);

        // random: mostly well-formed instruction runs, some bare writes, reads and nops
        phase = 0;
        while (words_sent < 550) begin
            if (words_sent / 100 != phase) begin
                phase = words_sent / 100;
                case (phase % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                    default: begin send_idle_pct = 14; recv_stall_pct = 14; end
                endcase
                if (phase == 2) hold_req = 1;
            end
            sel = $urandom_range(19);
            keys = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
            if (sel < 15) run_instr(pick_instr(), keys, 8'($urandom));
            else if (sel < 17) put(OP_READ, ($urandom_range(7) == 0) ? 12'($urandom)
                                   : 12'($urandom_range(255)), 8'($urandom), keys, 8'($urandom));
            else if (sel < 19) put(OP_WRITE, 12'($urandom), 8'($urandom), keys, 8'($urandom));
            else put(OP_NOP, 12'($urandom), 8'($urandom), keys, 8'($urandom));
        end
        @(negedge aclk);
        s_valid = 0;

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d words, %0d instructions run, %0d results checked.",
                 words_sent, sb.execs, sb.checked);
        $display("Sprite draws: %0d, screen clears: %0d, errors: %0d.",
                 sb.draws, sb.clears, sb.errors);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
